// ----- hw/rtl/dlm_pkg.sv -----
`timescale 1ns / 1ps
package dlm_pkg;

  localparam int ADDR_W = 12;

  typedef enum logic [2:0] {
    CMD_WEIGHT = 3'd0,
    CMD_BIAS   = 3'd1,
    CMD_IDROP  = 3'd2,
    CMD_ODROP  = 3'd3,
    CMD_SAMPLE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  row_index;
    logic [5:0]  col_index;
    logic signed [15:0] value;
    logic        drop_flag;
    logic        last_sample;
  } req_t;

  typedef struct packed {
    logic [5:0]  out_index;
    logic signed [31:0] z_value;
    logic        dropped;
    logic        last;
  } res_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              wr_weight;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [15:0] data;
    logic              flag;
    logic              mul_en;
    logic              acc_en;
    logic              add_en;
    logic              first;
    logic              load_out;
    logic              shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic               dropped;
  } slot_t;

endpackage

// ----- hw/rtl/dlm_cell.sv -----
`timescale 1ns / 1ps
module dlm_cell #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  dlm_pkg::cell_ctrl_t ctrl,
  input  logic               wr_col,
  input  logic               wr_bias,
  input  logic               wr_odrop,
  input  dlm_pkg::slot_t     slot_in,
  output dlm_pkg::slot_t     slot
);
  import dlm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [15:0] wmem [DEPTH];
  logic signed [15:0] w_q;
  logic signed [15:0] bias;
  logic               odrop;
  logic signed [31:0] prod;
  logic signed [39:0] acc;
  logic signed [39:0] base;
  logic signed [40:0] sum;
  logic signed [39:0] acc_next;
  slot_t              own;

  // weight memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.wr_weight && wr_col) begin
      wmem[ctrl.wr_addr[AW-1:0]] <= ctrl.data;
    end
    w_q <= wmem[ctrl.rd_addr[AW-1:0]];
  end

  // bias and output drop bit
  always_ff @(posedge clk) begin
    if (wr_bias) begin
      bias <= ctrl.data;
    end
    if (rst) begin
      odrop <= 1'b0;
    end else if (wr_odrop) begin
      odrop <= ctrl.flag;
    end
  end

  // accumulate with 40-bit saturation
  always_comb begin
    base = ctrl.first ? {{12{bias[15]}}, bias, 12'd0} : acc;
    sum  = {base[39], base} + {{9{prod[31]}}, prod};
    if (sum[40] != sum[39]) begin
      acc_next = sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      acc_next = sum[39:0];
    end
    if (!(ctrl.add_en && !odrop)) begin
      acc_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= ctrl.data * w_q;
    end
    if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

  // result of this neuron, 32-bit saturation
  always_comb begin
    own.dropped = odrop;
    if (odrop) begin
      own.z = 32'sd0;
    end else if (acc[39:31] != {9{acc[31]}}) begin
      own.z = acc[39] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      own.z = acc[31:0];
    end
  end

  // result slot, shifts toward cell zero
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      slot <= own;
    end else if (ctrl.shift) begin
      slot <= slot_in;
    end
  end

endmodule

// ----- hw/rtl/dense_layer_mac_with_dropout_unit.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake             | payload
// req      | in        | req_valid / req_stall | dlm_pkg::req_t
// res      | out       | res_valid / res_stall | dlm_pkg::res_t
// cfg      | in        | cfg_we                | cfg_data (out_count)
// A sample steps through weight read from each cell's memory, multiply,
// accumulate, and return to idle. A last sample then loads the result slots
// and shifts the results out along the cell row, the next as each is taken.
// Synchronous reset clears masks and position and sets out_count to 64.
// req_stall is high while a sample or the result drain is in progress.
module dense_layer_mac_with_dropout_unit #(
  parameter int MAX_INPUTS  = 256,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dlm_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output dlm_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data
);
  import dlm_pkg::*;

  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int PW = $clog2(MAX_INPUTS + 1);
  localparam int CW = $clog2(MAX_OUTPUTS + 1);

  state_t             state, state_next;
  logic [6:0]         out_count;
  logic [PW-1:0]      pos;
  logic               idrop [MAX_INPUTS];
  logic signed [15:0] samp;
  logic               samp_last;
  logic               samp_add;
  logic               samp_first;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      n_out;
  logic               req_take;
  logic               res_take;
  logic               row_ok;
  logic               pos_ok;
  cell_ctrl_t         ctrl;
  logic [MAX_OUTPUTS-1:0] wr_wcol;
  logic [MAX_OUTPUTS-1:0] wr_bias;
  logic [MAX_OUTPUTS-1:0] wr_odrop;
  slot_t              slots [MAX_OUTPUTS+1];

  assign req_take = req_valid && !req_stall;
  assign res_take = res_valid && !res_stall;
  assign row_ok   = int'(req.row_index) < MAX_INPUTS;
  assign pos_ok   = int'(pos) < MAX_INPUTS;

  // outputs in use, clamped
  always_comb begin
    if (out_count == 7'd0) begin
      n_out = CW'(1);
    end else if (int'(out_count) > MAX_OUTPUTS) begin
      n_out = CW'(MAX_OUTPUTS);
    end else begin
      n_out = CW'(out_count);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    res_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_take && req.cmd == CMD_SAMPLE) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = samp_last ? ST_LOAD : ST_IDLE;
      ST_LOAD: state_next = ST_DRAIN;
      ST_DRAIN: begin
        res_valid = 1'b1;
        if (res_take && cnt == n_out - CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sample capture, position, out_count and result count
  always_ff @(posedge clk) begin
    if (req_take && req.cmd == CMD_SAMPLE) begin
      samp       <= req.value;
      samp_last  <= req.last_sample;
      samp_first <= (pos == '0);
      samp_add   <= pos_ok && !idrop[pos[AW-1:0]];
    end
    if (rst) begin
      pos       <= '0;
      out_count <= 7'd64;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        out_count <= cfg_data;
      end
      if (req_take && req.cmd == CMD_SAMPLE && pos_ok) begin
        pos <= pos + PW'(1);
      end else if (state == ST_ACC && samp_last) begin
        pos <= '0;
      end
      if (state == ST_LOAD) begin
        cnt <= '0;
      end else if (res_take) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // input drop mask
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_INPUTS; i++) begin
      if (rst) begin
        idrop[i] <= 1'b0;
      end else if (req_take && req.cmd == CMD_IDROP && row_ok && int'(req.row_index) == i) begin
        idrop[i] <= req.drop_flag;
      end
    end
  end

  // cell control
  always_comb begin
    ctrl.wr_weight = req_take && req.cmd == CMD_WEIGHT && row_ok;
    ctrl.wr_addr   = ADDR_W'(req.row_index);
    ctrl.rd_addr   = ADDR_W'(pos - PW'(1));
    ctrl.data      = (state == ST_IDLE) ? req.value : samp;
    ctrl.flag      = req.drop_flag;
    ctrl.mul_en    = state == ST_MUL;
    ctrl.acc_en    = state == ST_ACC;
    ctrl.add_en    = samp_add;
    ctrl.first     = samp_first;
    ctrl.load_out  = state == ST_LOAD;
    ctrl.shift     = res_take;
    for (int k = 0; k < MAX_OUTPUTS; k++) begin
      wr_wcol[k]  = int'(req.col_index) == k;
      wr_bias[k]  = req_take && req.cmd == CMD_BIAS && int'(req.col_index) == k;
      wr_odrop[k] = req_take && req.cmd == CMD_ODROP && int'(req.col_index) == k;
    end
  end

  // row of neuron cells
  assign slots[MAX_OUTPUTS] = '0;
  for (genvar k = 0; k < MAX_OUTPUTS; k++) begin : g_cell
    dlm_cell #(.DEPTH(MAX_INPUTS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr_col   (wr_wcol[k]),
      .wr_bias  (wr_bias[k]),
      .wr_odrop (wr_odrop[k]),
      .slot_in  (slots[k+1]),
      .slot     (slots[k])
    );
  end

  assign res.out_index = 6'(cnt);
  assign res.z_value   = slots[0].z;
  assign res.dropped   = slots[0].dropped;
  assign res.last      = cnt == n_out - CW'(1);

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cnt < n_out) else $error("result count beyond outputs in use");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_take && res.last) |=> state == ST_IDLE) else $error("no return after last result");
  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> req_stall) else $error("request taken during drain");
  a_pos_reset: assert property (@(posedge clk) disable iff (rst)
    (res_take && res.last) |=> pos == '0) else $error("position not cleared");

endmodule

// ----- verif/dlm_checker.sv -----
`timescale 1ns / 1ps
module dlm_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  dlm_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_stall,
  input  dlm_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data,
  output int            fail_count,
  output int            pending
);
  import dlm_pkg::*;

  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint Z_HI   = 64'sd2147483647;
  localparam longint Z_LO   = -Z_HI - 1;

  // layer model state
  logic signed [15:0] weights [0:16383];
  logic signed [15:0] biases [0:63];
  logic               in_mask [0:255];
  logic               out_mask [0:63];
  longint             acc [0:63];
  int                 position;
  int                 neurons;
  res_t               expected_results [$];

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // update the layer model with one accepted request
  task automatic predict_layer(input req_t r);
    int   n;
    res_t e;
    case (r.cmd)
      CMD_WEIGHT: weights[{r.row_index, r.col_index}] = r.value;
      CMD_BIAS:   biases[r.col_index] = r.value;
      CMD_IDROP:  in_mask[r.row_index] = r.drop_flag;
      CMD_ODROP:  out_mask[r.col_index] = r.drop_flag;
      CMD_SAMPLE: begin
        if (position == 0)
          for (int k = 0; k < 64; k++) acc[k] = longint'(biases[k]) * 4096;
        if (position < 256) begin
          if (!in_mask[position])
            for (int k = 0; k < 64; k++)
              if (!out_mask[k])
                acc[k] = clip(acc[k] + longint'(r.value) *
                              longint'(weights[position*64+k]), ACC_LO, ACC_HI);
          position++;
        end
        if (r.last_sample) begin
          n = (neurons < 1) ? 1 : (neurons > 64 ? 64 : neurons);
          for (int k = 0; k < n; k++) begin
            e.out_index = k[5:0];
            e.dropped   = out_mask[k];
            e.z_value   = out_mask[k] ? 32'sd0 : 32'(clip(acc[k], Z_LO, Z_HI));
            e.last      = (k + 1 == n);
            expected_results.push_back(e);
          end
          position = 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      for (int i = 0; i < 256; i++) in_mask[i] = 1'b0;
      for (int i = 0; i < 64; i++) begin
        out_mask[i] = 1'b0;
        biases[i] = '0;
      end
      position = 0;
      neurons = 64;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) neurons = cfg_data;
      if (req_valid && !req_stall) predict_layer(req);
      // compare each accepted result with the oldest expectation
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", res);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (res !== e) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, res);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import dlm_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 0;
  res_t res;
  logic cfg_we = 0;
  logic [6:0] cfg_data = '0;
  int fail_count;
  int pending;
  logic quiet = 0;
  logic hold_off = 0;
  int inputs_used = 2;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dense_layer_mac_with_dropout_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  dlm_checker chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off) res_stall <= 1'b1;
    else res_stall <= !quiet && ($urandom_range(99) < 10);
  end

  // send one request, idling at random before it
  task automatic send_request(input req_t r);
    while (!quiet && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send_fields(input logic [2:0] c, input int row, input int col,
                             input int val, input bit flag, input bit lst);
    req_t r;
    r.cmd = c;
    r.row_index = row[7:0];
    r.col_index = col[5:0];
    r.value = val[15:0];
    r.drop_flag = flag;
    r.last_sample = lst;
    send_request(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_outputs(input int n);
    wait_drained();
    cfg_data <= n[6:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // write every weight of the first n rows and every bias
  task automatic load_layer(input int n, input bit extreme);
    for (int c = 0; c < 64; c++)
      send_fields(CMD_BIAS, 0, c, extreme ? ((c & 1) ? -32768 : 32767)
                                          : $urandom_range(65535), 0, 0);
    for (int row = 0; row < n; row++)
      for (int c = 0; c < 64; c++)
        send_fields(CMD_WEIGHT, row, c, extreme ? ((c & 1) ? -32768 : 32767)
                                                : $urandom_range(65535), 0, 0);
  endtask

  // stream one vector of the given length
  task automatic send_vector(input int len, input bit extreme);
    for (int i = 0; i < len; i++)
      send_fields(CMD_SAMPLE, $urandom_range(255), $urandom_range(63),
                  extreme ? ((i & 1) ? -32768 : 32767) : $urandom_range(65535),
                  $urandom_range(1), i == len - 1);
  endtask

  initial begin
    int item_count;
    int pick;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    quiet <= 1'b1;
    set_outputs(64);
    load_layer(inputs_used, 1);
    // directed: extremes, saturation, drop masks, unused codes
    send_vector(2, 1);
    send_fields(CMD_IDROP, 1, 0, 0, 1, 0);
    send_fields(CMD_ODROP, 0, 63, 0, 1, 0);
    send_fields(CMD_ODROP, 0, 0, 0, 1, 0);
    send_fields(3'd5, 255, 63, -1, 1, 1);
    send_fields(3'd6, 0, 0, 0, 0, 0);
    send_fields(3'd7, 255, 63, 32767, 1, 1);
    send_vector(2, 1);
    send_fields(CMD_ODROP, 0, 0, 0, 0, 0);
    send_vector(1, 0);
    set_outputs(0);
    send_vector(2, 0);
    set_outputs(127);
    send_vector(2, 0);
    set_outputs(1);
    send_vector(1, 1);
    quiet <= 1'b0;
    // random: mostly well-formed vectors with store updates and noise
    item_count = 0;
    while (item_count < 80) begin
      pick = $urandom_range(99);
      if (item_count == 40) quiet <= 1'b1;
      if (item_count == 56) quiet <= 1'b0;
      if (pick < 5) begin
        set_outputs($urandom_range(127));
        item_count++;
      end else if (pick < 15) begin
        send_fields($urandom_range(1), $urandom_range(inputs_used - 1),
                    $urandom_range(63), $urandom_range(65535), 0, 0);
        item_count++;
      end else if (pick < 22) begin
        send_fields($urandom_range(3, 2), $urandom_range(255), $urandom_range(63),
                    0, $urandom_range(99) < 30, 0);
        item_count++;
      end else if (pick < 25) begin
        send_fields($urandom_range(7, 5), $urandom_range(255), $urandom_range(63),
                    $urandom_range(65535), $urandom_range(1), $urandom_range(1));
      end else begin
        pick = $urandom_range(1, inputs_used);
        send_vector(pick, $urandom_range(99) < 10);
        item_count += pick;
      end
    end
    // deep vector past the input limit, every output dropped so unloaded rows stay unused
    for (int c = 0; c < 64; c++)
      send_fields(CMD_ODROP, 0, c, 0, 1, 0);
    set_outputs(8);
    send_vector(258, 0);
    // receiver holds off while the sender keeps offering vectors
    set_outputs(64);
    fork
      begin
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_vector(2, 0);
        send_vector(2, 0);
        send_vector(1, 0);
        req_valid <= 1'b0;
      end
    join
    wait_drained();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- dense_layer_mac_with_dropout_unit.f -----
hw/rtl/dlm_pkg.sv
hw/rtl/dlm_cell.sv
hw/rtl/dense_layer_mac_with_dropout_unit.sv
verif/dlm_checker.sv
verif/tb.sv
